@@ design/cps_pkg.sv @@
// Shared constants and word types for the closest pair search block.
package cps_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DIST_W     = 34;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               last_point;
	} cps_in_t;

	typedef struct packed {
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic [32:0]        dist_squared;
		logic               pair_valid;
		logic               overflowed;
	} cps_res_t;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic              rd_latch;
		logic [ADDR_W-1:0] rd_addr;
		logic              clear;
	} cps_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             pipe_busy;
	} cps_status_t;

endpackage

@@ design/closest_pair_search.sv @@
// Top level of the brute-force closest pair search.
//
//   channel  ports                   handshake
//   input    point (cps_in_t)        taken when start && !busy
//   output   result (cps_res_t)      valid for the one cycle done is high
//
// Points load one per cycle while idle into a MAX_POINTS-word store with one
// write and one read port. After the last point come a setup state, for each
// i < n-1 a latch state fetching point i and a scan state per j > i (paced by
// the one read port), a drain state until the distance pipeline empties, and
// done high for one cycle. busy is low only when a new point can be taken.
// Reset clears counts and best pair; the store needs no clearing pass.
module closest_pair_search import cps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cps_in_t  point,
	output logic     busy,
	output logic     done,
	output cps_res_t result
);

	cps_ctrl_t   ctrl;
	cps_status_t status;

	cps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_point (point.last_point),
		.status     (status),
		.ctrl       (ctrl),
		.busy       (busy),
		.done       (done)
	);

	cps_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.point  (point),
		.status (status),
		.result (result)
	);

`ifndef SYNTH
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside search");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not idle after result");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !point.last_point) |=> !busy) else $error("busy after load");

	a_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.pair_valid) |-> (result.dist_squared == '0))
		else $error("distance without pair");
`endif

endmodule

@@ design/cps_datapath.sv @@
// Point store, distance pipeline and best-pair registers.
module cps_datapath import cps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cps_ctrl_t   ctrl,
	input  cps_in_t     point,
	output cps_status_t status,
	output cps_res_t    result
);

	logic [31:0]        mem [MAX_POINTS];
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;

	logic [31:0]        rd_data_s1;
	logic               rd_vld_s1;
	logic               rd_lat_s1;
	logic [31:0]        pi_q;

	logic               cmp_vld_s2;
	logic signed [16:0] dx_s2;
	logic signed [16:0] dy_s2;
	logic [31:0]        pa_s2;
	logic [31:0]        pb_s2;

	logic               cmp_vld_s3;
	logic [31:0]        sqx_s3;
	logic [31:0]        sqy_s3;
	logic [31:0]        pa_s3;
	logic [31:0]        pb_s3;

	logic [DIST_W-1:0]  best_q;
	logic [31:0]        best_a_q;
	logic [31:0]        best_b_q;

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [33:0] px;
	logic signed [33:0] py;
	logic [32:0]        dist_sum;
	logic               room;
	logic               pair_ok;

	assign room = count_q < CNT_W'(MAX_POINTS);

	always_ff @(posedge clk) begin
		if (ctrl.load && room) begin
			mem[count_q[ADDR_W-1:0]] <= {point.point_x, point.point_y};
		end
		if (ctrl.rd_en) begin
			rd_data_s1 <= mem[ctrl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.load) begin
			if (room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// s1: difference against the held point i
	assign dx = $signed({rd_data_s1[31], rd_data_s1[31:16]}) - $signed({pi_q[31], pi_q[31:16]});
	assign dy = $signed({rd_data_s1[15], rd_data_s1[15:0]}) - $signed({pi_q[15], pi_q[15:0]});

	// s2: squares
	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;

	// s3: sum
	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_lat_s1  <= 1'b0;
			cmp_vld_s2 <= 1'b0;
			cmp_vld_s3 <= 1'b0;
		end else begin
			rd_vld_s1  <= ctrl.rd_en;
			rd_lat_s1  <= ctrl.rd_latch;
			cmp_vld_s2 <= rd_vld_s1 && !rd_lat_s1;
			cmp_vld_s3 <= cmp_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_lat_s1) begin
			pi_q <= rd_data_s1;
		end
		dx_s2  <= dx;
		dy_s2  <= dy;
		pa_s2  <= pi_q;
		pb_s2  <= rd_data_s1;
		sqx_s3 <= px[31:0];
		sqy_s3 <= py[31:0];
		pa_s3  <= pa_s2;
		pb_s3  <= pb_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '1;
			best_a_q <= '0;
			best_b_q <= '0;
		end else if (ctrl.clear) begin
			best_q   <= '1;
			best_a_q <= '0;
			best_b_q <= '0;
		end else if (cmp_vld_s3 && ({1'b0, dist_sum} < best_q)) begin
			best_q   <= {1'b0, dist_sum};
			best_a_q <= pa_s3;
			best_b_q <= pb_s3;
		end
	end

	assign pair_ok = count_q >= CNT_W'(2);

	assign status.count     = count_q;
	assign status.pipe_busy = rd_vld_s1 || cmp_vld_s2 || cmp_vld_s3;

	assign result.first_x      = pair_ok ? best_a_q[31:16] : '0;
	assign result.first_y      = pair_ok ? best_a_q[15:0]  : '0;
	assign result.second_x     = pair_ok ? best_b_q[31:16] : '0;
	assign result.second_y     = pair_ok ? best_b_q[15:0]  : '0;
	assign result.dist_squared = pair_ok ? best_q[32:0]    : '0;
	assign result.pair_valid   = pair_ok;
	assign result.overflowed   = ovf_q;

endmodule

@@ design/cps_ctrl.sv @@
// Sequencer for loading, pair scanning, pipeline drain and result word.
module cps_ctrl import cps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_point,
	input  cps_status_t status,
	output cps_ctrl_t   ctrl,
	output logic        busy,
	output logic        done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic              j_end;
	logic              i_end;

	assign j_end = {1'b0, j_q} == (status.count - CNT_W'(1));
	assign i_end = {1'b0, i_q} == (status.count - CNT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && last_point) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					i_q <= '0;
					if (status.count >= CNT_W'(2)) begin
						state_q <= ST_LATCH;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_LATCH: begin
					j_q     <= i_q + ADDR_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_end) begin
						if (i_end) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q     <= i_q + ADDR_W'(1);
							state_q <= ST_LATCH;
						end
					end else begin
						j_q <= j_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = state_q == ST_OUT;
	assign ctrl.load     = (state_q == ST_IDLE) && start;
	assign ctrl.rd_en    = (state_q == ST_LATCH) || (state_q == ST_SCAN);
	assign ctrl.rd_latch = state_q == ST_LATCH;
	assign ctrl.rd_addr  = (state_q == ST_LATCH) ? i_q : j_q;
	assign ctrl.clear    = state_q == ST_OUT;

endmodule
